// ===== rtl/tks_pkg.sv =====
package tks_pkg;

  localparam int MAX_KEEP     = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int KEEP_LIM     = (MAX_KEEP < RESULT_LIMIT) ? MAX_KEEP : RESULT_LIMIT;
  localparam int CNT_W        = $clog2(MAX_KEEP + 1);
  localparam int IDX_W        = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  localparam int DATA_W   = 32;
  localparam int KC_W     = 5;
  localparam int RANK_W   = 4;
  localparam int CFG_IDX_W = 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEEP_COUNT = 1'b0,
    CFG_WEIGHT_THR = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ST_INSERT,
    ST_DRAIN
  } back_state_t;

  typedef struct packed {
    logic [DATA_W-1:0]        row;
    logic [DATA_W-1:0]        gamma;
    logic signed [DATA_W-1:0] weight;
    logic                     keep;
    logic                     last;
  } hit_item_t;

  function automatic logic [CNT_W-1:0] eff_keep(input logic [KC_W-1:0] kc);
    logic [CNT_W-1:0] k;
    if (kc == '0) begin
      k = CNT_W'(1);
    end else if (32'(kc) > KEEP_LIM) begin
      k = CNT_W'(KEEP_LIM);
    end else begin
      k = CNT_W'(kc);
    end
    return k;
  endfunction

endpackage

// ===== rtl/top_k_hit_selector.sv =====
// An accepted hit is registered in the queue, then popped and inserted into the kept list
// in ST_INSERT; after the last hit of a query the back drains the list through the output
// register in ST_DRAIN. Throughput: one hit per cycle in ST_INSERT, set by the parallel
// compare insert; the drain emits one result per cycle while out_pop frees the output,
// the queue takes up to 4 hits meanwhile, then holds in_full high until the drain is done.
// Reset (rst_n low, synchronous): queue and output empty, no hits kept,
// keep_count 16, weight_threshold -2147483648.
module top_k_hit_selector
  import tks_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [DATA_W-1:0]        in_row,
  input  logic [DATA_W-1:0]        in_gamma,
  input  logic signed [DATA_W-1:0] in_weight,
  input  logic                     in_last,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [DATA_W-1:0]        out_hit_row,
  output logic [DATA_W-1:0]        out_hit_gamma,
  output logic signed [DATA_W-1:0] out_hit_weight,
  output logic [RANK_W-1:0]        out_rank,
  output logic                     out_found,
  output logic                     out_final_res,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  logic [KC_W-1:0]          keep_count_r, keep_count_nxt;
  logic signed [DATA_W-1:0] weight_thr_r, weight_thr_nxt;
  logic                     q_full, q_push, q_pop, q_empty;
  hit_item_t                q_in_item, q_out_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    keep_count_nxt = keep_count_r;
    weight_thr_nxt = weight_thr_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_KEEP_COUNT: keep_count_nxt = cfg_data[KC_W-1:0];
        CFG_WEIGHT_THR: weight_thr_nxt = cfg_data;
        default: begin
          keep_count_nxt = keep_count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= KC_W'(16);
      weight_thr_r <= {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      keep_count_r <= keep_count_nxt;
      weight_thr_r <= weight_thr_nxt;
    end
  end

  tks_front u_front (
    .in_push    (in_push),
    .in_full    (in_full),
    .in_row     (in_row),
    .in_gamma   (in_gamma),
    .in_weight  (in_weight),
    .in_last    (in_last),
    .weight_thr (weight_thr_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_in_item)
  );

  tks_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .empty     (q_empty)
  );

  tks_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .keep_count     (keep_count_r),
    .q_empty        (q_empty),
    .q_item         (q_out_item),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_hit_row    (out_hit_row),
    .out_hit_gamma  (out_hit_gamma),
    .out_hit_weight (out_hit_weight),
    .out_rank       (out_rank),
    .out_found      (out_found),
    .out_final_res  (out_final_res)
  );

endmodule

// ===== rtl/tks_front.sv =====
module tks_front
  import tks_pkg::*;
(
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [DATA_W-1:0]        in_row,
  input  logic [DATA_W-1:0]        in_gamma,
  input  logic signed [DATA_W-1:0] in_weight,
  input  logic                     in_last,
  input  logic signed [DATA_W-1:0] weight_thr,
  input  logic                     q_full,
  output logic                     q_push,
  output hit_item_t                q_item
);

  logic keep;

  assign keep    = (in_weight >= weight_thr);
  assign in_full = q_full;

  // pass every transaction so the back trims the kept list on each one
  assign q_push  = in_push && !q_full;

  always_comb begin
    q_item.row    = in_row;
    q_item.gamma  = in_gamma;
    q_item.weight = in_weight;
    q_item.keep   = keep;
    q_item.last   = in_last;
  end

endmodule

// ===== rtl/tks_queue.sv =====
module tks_queue
  import tks_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  hit_item_t push_item,
  output logic      full,
  input  logic      pop,
  output hit_item_t pop_item,
  output logic      empty
);

  hit_item_t         slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/tks_back.sv =====
module tks_back
  import tks_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [KC_W-1:0]          keep_count,
  input  logic                     q_empty,
  input  hit_item_t                q_item,
  output logic                     q_pop,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [DATA_W-1:0]        out_hit_row,
  output logic [DATA_W-1:0]        out_hit_gamma,
  output logic signed [DATA_W-1:0] out_hit_weight,
  output logic [RANK_W-1:0]        out_rank,
  output logic                     out_found,
  output logic                     out_final_res
);

  back_state_t state_r, state_nxt;

  logic [DATA_W-1:0]        rows_r    [MAX_KEEP];
  logic [DATA_W-1:0]        gammas_r  [MAX_KEEP];
  logic signed [DATA_W-1:0] weights_r [MAX_KEEP];
  logic [DATA_W-1:0]        rows_nxt    [MAX_KEEP];
  logic [DATA_W-1:0]        gammas_nxt  [MAX_KEEP];
  logic signed [DATA_W-1:0] weights_nxt [MAX_KEEP];

  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]        out_row_r, out_row_nxt;
  logic [DATA_W-1:0]        out_gamma_r, out_gamma_nxt;
  logic signed [DATA_W-1:0] out_weight_r, out_weight_nxt;
  logic [RANK_W-1:0]        out_rank_r, out_rank_nxt;
  logic                     out_found_r, out_found_nxt;
  logic                     out_final_r, out_final_nxt;

  logic [CNT_W-1:0]    k_eff, k_m1, tot_eff, total_after;
  logic [MAX_KEEP-1:0] ins;
  logic                take, load, last_emit;

  assign k_eff   = eff_keep(keep_count);
  assign k_m1    = k_eff - CNT_W'(1);
  assign tot_eff = (total_r > k_eff) ? k_eff : total_r;

  // newcomer belongs at or before slot i
  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      ins[i] = (CNT_W'(i) >= tot_eff) ||
               (q_item.weight > weights_r[i]) ||
               ((q_item.weight == weights_r[i]) && (q_item.row < rows_r[i]));
    end
  end

  assign take        = q_item.keep && ins[k_m1[IDX_W-1:0]];
  assign total_after = (take && (tot_eff < k_eff)) ? tot_eff + CNT_W'(1) : tot_eff;
  assign q_pop       = (state_r == ST_INSERT) && !q_empty;
  assign load        = (state_r == ST_DRAIN) && (!out_valid_r || out_pop);
  assign last_emit   = (total_r <= CNT_W'(1));

  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      rows_nxt[i]    = rows_r[i];
      gammas_nxt[i]  = gammas_r[i];
      weights_nxt[i] = weights_r[i];
    end
    if (q_pop && take) begin
      for (int i = 0; i < MAX_KEEP; i++) begin
        if (ins[i]) begin
          if (i == 0 || !ins[(i == 0) ? 0 : i - 1]) begin
            rows_nxt[i]    = q_item.row;
            gammas_nxt[i]  = q_item.gamma;
            weights_nxt[i] = q_item.weight;
          end else begin
            rows_nxt[i]    = rows_r[(i == 0) ? 0 : i - 1];
            gammas_nxt[i]  = gammas_r[(i == 0) ? 0 : i - 1];
            weights_nxt[i] = weights_r[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end else if (load) begin
      // advance the list toward slot 0
      for (int i = 0; i < MAX_KEEP - 1; i++) begin
        rows_nxt[i]    = rows_r[i + 1];
        gammas_nxt[i]  = gammas_r[i + 1];
        weights_nxt[i] = weights_r[i + 1];
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    rank_nxt       = rank_r;
    out_valid_nxt  = out_valid_r;
    out_row_nxt    = out_row_r;
    out_gamma_nxt  = out_gamma_r;
    out_weight_nxt = out_weight_r;
    out_rank_nxt   = out_rank_r;
    out_found_nxt  = out_found_r;
    out_final_nxt  = out_final_r;
    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_INSERT: begin
        if (q_pop) begin
          total_nxt = total_after;
          rank_nxt  = '0;
          if (q_item.last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (load) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = (total_r != '0);
          out_row_nxt    = (total_r != '0) ? rows_r[0] : '0;
          out_gamma_nxt  = (total_r != '0) ? gammas_r[0] : '0;
          out_weight_nxt = (total_r != '0) ? weights_r[0] : '0;
          out_rank_nxt   = rank_r;
          out_final_nxt  = last_emit;
          rank_nxt       = rank_r + RANK_W'(1);
          total_nxt      = (total_r != '0) ? total_r - CNT_W'(1) : '0;
          if (last_emit) begin
            state_nxt = ST_INSERT;
          end
        end
      end
      default: begin
        state_nxt = ST_INSERT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INSERT;
      total_r     <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      rows_r[i]    <= rows_nxt[i];
      gammas_r[i]  <= gammas_nxt[i];
      weights_r[i] <= weights_nxt[i];
    end
    out_row_r    <= out_row_nxt;
    out_gamma_r  <= out_gamma_nxt;
    out_weight_r <= out_weight_nxt;
    out_rank_r   <= out_rank_nxt;
    out_found_r  <= out_found_nxt;
    out_final_r  <= out_final_nxt;
  end

  assign out_empty      = !out_valid_r;
  assign out_hit_row    = out_row_r;
  assign out_hit_gamma  = out_gamma_r;
  assign out_hit_weight = out_weight_r;
  assign out_rank       = out_rank_r;
  assign out_found      = out_found_r;
  assign out_final_res  = out_final_r;

endmodule
